// ===== rtl/uer_pkg.sv =====
// shared types and constants for the ultrasonic echo ranger
`default_nettype none

package uer_pkg;

  localparam int unsigned WidthW = 16;
  localparam int unsigned DistW  = 10;
  localparam int unsigned CharW  = 6;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // register indexes on the write port
  localparam logic [CfgIdxW-1:0] CfgTrigTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRiseTmo   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFallTmo   = 2'd2;

  localparam logic [7:0]        TrigTicksRst = 8'd10;
  localparam logic [WidthW-1:0] RiseTmoRst   = 16'd10000;
  localparam logic [WidthW-1:0] FallTmoRst   = 16'd50000;

  // width * 17 / 1000 as width * ceil(2^31 / 1000) * 17 >> 31, exact for 16-bit widths
  localparam int unsigned    DistShift = 31;
  localparam logic [25:0]    DistMul   = 26'd36507228;

  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  typedef struct packed {
    logic              trigger;
    logic              done;
    logic [WidthW-1:0] width;
  } meas_t;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger.sv =====
// ultrasonic echo ranger top level
//
// each input item is one microsecond tick with the sampled echo level; each
// accepted item yields exactly one result item with the trigger drive for that
// tick, a done flag and, on done, the distance in cm and three ascii digits.
// the block runs trigger, wait-for-rise and echo-timing phases back to back.
// path: an item passes three registers (sequencer, distance multiply,
// digits) before its result is on the output ports.
// throughput: one item per cycle while out_ready_i is high; the sequencer
// state updates once per accepted item; the distance multiplier is pipelined.
// stall: when out_ready_i is low the three stages fill and in_ready_o drops;
// nothing is dropped and held items keep their values.
// reset: registers load 10, 10000 and 50000 ticks, the sequencer starts in
// the trigger phase with zero counts, and the pipeline is empty.
// configuration writes take effect at the next edge; the user makes them while idle, unenforced by the block.
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [uer_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [uer_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        echo_level_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             trigger_level_o,
  output logic                             done_res_o,
  output logic [uer_pkg::DistW-1:0]        distance_cm_o,
  output logic [uer_pkg::CharW-1:0]        hundreds_char_o,
  output logic [uer_pkg::CharW-1:0]        tens_char_o,
  output logic [uer_pkg::CharW-1:0]        ones_char_o
);

  logic           meas_valid, meas_ready;
  uer_pkg::meas_t meas;

  uer_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .echo_level_i (echo_level_i),
    .meas_valid_o (meas_valid),
    .meas_ready_i (meas_ready),
    .meas_o       (meas)
  );

  uer_conv u_conv (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .meas_valid_i    (meas_valid),
    .meas_ready_o    (meas_ready),
    .meas_i          (meas),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .trigger_level_o (trigger_level_o),
    .done_res_o      (done_res_o),
    .distance_cm_o   (distance_cm_o),
    .hundreds_char_o (hundreds_char_o),
    .tens_char_o     (tens_char_o),
    .ones_char_o     (ones_char_o)
  );

endmodule

`default_nettype wire

// ===== rtl/uer_ctrl.sv =====
// measurement sequencer: trigger, wait for rise, time the echo high phase
`default_nettype none

module uer_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [uer_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [uer_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        echo_level_i,
  output logic                             meas_valid_o,
  input  wire logic                        meas_ready_i,
  output uer_pkg::meas_t                   meas_o
);

  localparam logic [1:0] PhTrig = 2'd0;
  localparam logic [1:0] PhRise = 2'd1;
  localparam logic [1:0] PhHigh = 2'd2;

  logic [7:0]                  trig_ticks_q;
  logic [uer_pkg::WidthW-1:0]  rise_tmo_q, fall_tmo_q;
  logic [1:0]                  phase_q, phase_d;
  logic [uer_pkg::WidthW-1:0]  phase_count_q, phase_count_d;
  logic [uer_pkg::WidthW-1:0]  echo_width_q, echo_width_d;
  logic [uer_pkg::WidthW-1:0]  trig_eff, rise_eff, fall_eff;
  logic [uer_pkg::WidthW-1:0]  pc_inc, ew_inc;
  logic                        valid_q;
  uer_pkg::meas_t              meas_q, meas_d;
  logic                        accept;

  assign in_ready_o   = !valid_q || meas_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign meas_valid_o = valid_q;
  assign meas_o       = meas_q;

  // a zero register acts as one
  assign trig_eff = (trig_ticks_q == 8'd0) ? 16'd1 : {8'd0, trig_ticks_q};
  assign rise_eff = (rise_tmo_q == 16'd0) ? 16'd1 : rise_tmo_q;
  assign fall_eff = (fall_tmo_q == 16'd0) ? 16'd1 : fall_tmo_q;
  assign pc_inc   = phase_count_q + 16'd1;
  assign ew_inc   = (echo_width_q != 16'hFFFF) ? echo_width_q + 16'd1 : echo_width_q;

  always_comb begin
    phase_d        = phase_q;
    phase_count_d  = phase_count_q;
    echo_width_d   = echo_width_q;
    meas_d.trigger = 1'b0;
    meas_d.done    = 1'b0;
    meas_d.width   = '0;
    case (phase_q)
      PhRise: begin
        if (echo_level_i) begin
          echo_width_d  = 16'd1;
          phase_count_d = 16'd1;
          phase_d       = PhHigh;
          if (fall_eff == 16'd1) begin
            meas_d.done   = 1'b1;
            meas_d.width  = 16'd1;
            phase_d       = PhTrig;
            phase_count_d = '0;
          end
        end else begin
          phase_count_d = pc_inc;
          if (pc_inc >= rise_eff) begin
            echo_width_d  = '0;
            meas_d.done   = 1'b1;
            phase_d       = PhTrig;
            phase_count_d = '0;
          end
        end
      end
      PhHigh: begin
        if (echo_level_i) begin
          echo_width_d  = ew_inc;
          phase_count_d = ew_inc;
          if (ew_inc >= fall_eff) begin
            meas_d.done   = 1'b1;
            meas_d.width  = ew_inc;
            phase_d       = PhTrig;
            phase_count_d = '0;
          end
        end else begin
          meas_d.done   = 1'b1;
          meas_d.width  = echo_width_q;
          phase_d       = PhTrig;
          phase_count_d = '0;
        end
      end
      default: begin
        meas_d.trigger = 1'b1;
        phase_count_d  = pc_inc;
        if (pc_inc >= trig_eff) begin
          phase_d       = PhRise;
          phase_count_d = '0;
        end else begin
          phase_d = PhTrig;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= uer_pkg::TrigTicksRst;
      rise_tmo_q   <= uer_pkg::RiseTmoRst;
      fall_tmo_q   <= uer_pkg::FallTmoRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uer_pkg::CfgTrigTicks: trig_ticks_q <= cfg_wdata_i[7:0];
        uer_pkg::CfgRiseTmo:   rise_tmo_q   <= cfg_wdata_i;
        uer_pkg::CfgFallTmo:   fall_tmo_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhTrig;
      phase_count_q <= '0;
      echo_width_q  <= '0;
      valid_q       <= 1'b0;
    end else begin
      if (accept) begin
        phase_q       <= phase_d;
        phase_count_q <= phase_count_d;
        echo_width_q  <= echo_width_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= meas_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uer_conv.sv =====
// width to centimetres and ascii digits, two pipeline stages
`default_nettype none

module uer_conv (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       meas_valid_i,
  output logic                            meas_ready_o,
  input  wire uer_pkg::meas_t             meas_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            trigger_level_o,
  output logic                            done_res_o,
  output logic [uer_pkg::DistW-1:0]       distance_cm_o,
  output logic [uer_pkg::CharW-1:0]       hundreds_char_o,
  output logic [uer_pkg::CharW-1:0]       tens_char_o,
  output logic [uer_pkg::CharW-1:0]       ones_char_o
);

  logic        s2_valid_q, s3_valid_q;
  logic        s2_ready, s3_ready;
  logic        s2_trig_q, s2_done_q;
  logic [10:0] s2_dist_q;
  logic [41:0] prod;

  logic [9:0]  dist_sat, digit_sat;
  logic [15:0] h_prod;
  logic [3:0]  hund;
  logic [6:0]  rem;
  logic [14:0] t_prod;
  logic [3:0]  tens, ones;

  logic                       trig_q, done_q;
  logic [uer_pkg::DistW-1:0]  dist_q;
  logic [uer_pkg::CharW-1:0]  hund_q, tens_q, ones_q;

  assign s3_ready     = !s3_valid_q || out_ready_i;
  assign s2_ready     = !s2_valid_q || s3_ready;
  assign meas_ready_o = s2_ready;

  assign prod = {26'd0, meas_i.width} * {16'd0, uer_pkg::DistMul};

  // saturate, then split into digits with reciprocal multiplies
  assign dist_sat  = (s2_dist_q > 11'd1023) ? 10'd1023 : s2_dist_q[9:0];
  assign digit_sat = (s2_dist_q > 11'd999) ? 10'd999 : s2_dist_q[9:0];
  assign h_prod    = {6'd0, digit_sat} * 16'd41;
  assign hund      = h_prod[15:12];
  assign rem       = 7'(digit_sat - {6'd0, hund} * 10'd100);
  assign t_prod    = {8'd0, rem} * 15'd205;
  assign tens      = t_prod[14:11];
  assign ones      = 4'(rem - {3'd0, tens} * 7'd10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= meas_valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && meas_valid_i) begin
      s2_trig_q <= meas_i.trigger;
      s2_done_q <= meas_i.done;
      s2_dist_q <= prod[uer_pkg::DistShift +: 11];
    end
    if (s3_ready && s2_valid_q) begin
      trig_q <= s2_trig_q;
      done_q <= s2_done_q;
      dist_q <= dist_sat;
      hund_q <= uer_pkg::AsciiZero + {2'd0, hund};
      tens_q <= uer_pkg::AsciiZero + {2'd0, tens};
      ones_q <= uer_pkg::AsciiZero + {2'd0, ones};
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign trigger_level_o = trig_q;
  assign done_res_o      = done_q;
  assign distance_cm_o   = dist_q;
  assign hundreds_char_o = hund_q;
  assign tens_char_o     = tens_q;
  assign ones_char_o     = ones_q;

endmodule

`default_nettype wire
